/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that an implication holds at each clock, reset masks it
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// assert that an expression holds in the cycle after a condition
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/mpfb_pkg.sv */
// package with constants and types of the page frame buffer
`timescale 1ns / 1ps
package mpfb_pkg;
    localparam int COLUMNS = 128;
    localparam int PAGES = 8;
    localparam int DEPTH = COLUMNS * PAGES;
    localparam int COL_W = $clog2(COLUMNS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROWS = PAGES * 8;

    typedef enum logic [2:0] {
        F_WRITE  = 3'd0,
        F_TOGGLE = 3'd1,
        F_CLEAR  = 3'd2,
        F_FILLED = 3'd3,
        F_HOLLOW = 3'd4,
        F_PATB   = 3'd5,
        F_PATO   = 3'd6,
        F_READ   = 3'd7
    } t_func;

    // classified command handed from front to back
    typedef struct packed {
        t_func       func;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic        pixel_value;
        logic [7:0]  pattern_period;
        logic [15:0] pattern_slope;
        logic        empty;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    typedef enum logic [3:0] {
        S_CLR_INIT, S_IDLE, S_CLR, S_PIX_RD, S_PIX_WR, S_RD, S_RD_WAIT,
        S_RECT_RD, S_RECT_WR, S_MOD, S_DONE
    } t_state;
endpackage

/* hdl/mpfb_ram.sv */
// generic single port ram with registered read
`timescale 1ns / 1ps
module mpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

/* hdl/mpfb_fifo.sv */
// two entry command queue between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpfb_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mpfb_pkg::t_cmd       i_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mpfb_pkg::t_cmd       o_cmd
);
    mpfb_pkg::t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_cmd;
    end

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `ASSERT_IMPL(a_ptr_full, i_clk, i_rst_n, r_cnt == 2'd2, r_wp == r_rp)
    `ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
endmodule

/* hdl/mpfb_front.sv */
// front end: takes an item and classifies it
`timescale 1ns / 1ps
module mpfb_front (
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_func,
    input  logic [7:0]           i_pos_x,
    input  logic [7:0]           i_pos_y,
    input  logic [7:0]           i_rect_width,
    input  logic [7:0]           i_rect_height,
    input  logic                 i_pixel_value,
    input  logic [7:0]           i_pattern_period,
    input  logic [15:0]          i_pattern_slope,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mpfb_pkg::t_cmd       o_cmd
);
    assign o_valid = i_valid;
    assign o_ready = i_ready;
    always_comb begin
        o_cmd.func = mpfb_pkg::t_func'(i_func);
        o_cmd.pos_x = i_pos_x;
        o_cmd.pos_y = i_pos_y;
        o_cmd.rect_width = i_rect_width;
        o_cmd.rect_height = i_rect_height;
        o_cmd.pixel_value = i_pixel_value;
        o_cmd.pattern_period = i_pattern_period;
        o_cmd.pattern_slope = i_pattern_slope;
        // rectangle with no area writes nothing
        o_cmd.empty = (i_rect_width == 8'd0) || (i_rect_height == 8'd0);
    end
endmodule

/* hdl/mpfb_back.sv */
// back end: walks memory for one command at a time
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpfb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mpfb_pkg::t_cmd       i_cmd,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_read_data,
    output logic                 o_clipped
);
    localparam int AW = mpfb_pkg::ADDR_W;

    mpfb_pkg::t_state r_state, n_state;
    mpfb_pkg::t_cmd r_cmd, n_cmd;
    logic [AW:0] r_clr, n_clr;
    logic [8:0] r_c, n_c, r_r, n_r;
    logic [8:0] r_cend, r_rend;
    logic r_clip, n_clip;
    logic [7:0] r_rdata, n_rdata;
    logic r_ovalid, n_ovalid;
    // pattern modulus: signed term and shift-subtract remainder
    logic [24:0] r_mag, n_mag;
    logic [4:0] r_mstep, n_mstep;
    logic [32:0] r_rem, n_rem;
    logic [24:0] term_w;
    logic signed [25:0] term_s;
    logic [32:0] trial;

    logic we;
    logic [AW-1:0] addr;
    logic [7:0] wdata, rdata;
    logic [7:0] bitm;
    logic in_buf;
    logic border;
    logic [AW-1:0] pix_addr;

    mpfb_ram #(.WIDTH(8), .DEPTH(mpfb_pkg::DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    assign in_buf = (r_c < 9'(mpfb_pkg::COLUMNS)) && (r_r < 9'(mpfb_pkg::ROWS));
    assign bitm = 8'h01 << r_r[2:0];
    assign pix_addr = AW'(({3'd0, r_r} >> 3) * mpfb_pkg::COLUMNS + {3'd0, r_c});
    assign border = (r_c == {1'b0, r_cmd.pos_x}) || (r_c == r_cend)
        || (r_r == {1'b0, r_cmd.pos_y}) || (r_r == r_rend);
    assign term_s = $signed({17'd0, r_c}) + $signed(r_cmd.pattern_slope) * $signed({1'b0, r_r});
    assign term_w = term_s[25] ? 25'(-term_s) : 25'(term_s);
    assign trial = {r_rem[31:0], r_mag[24]} - {25'd0, r_cmd.pattern_period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpfb_pkg::S_CLR_INIT;
            r_clr <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_c <= n_c;
        r_r <= n_r;
        r_clip <= n_clip;
        r_rdata <= n_rdata;
        r_mag <= n_mag;
        r_mstep <= n_mstep;
        r_rem <= n_rem;
        r_cend <= 9'({1'b0, n_cmd.pos_x} + {1'b0, n_cmd.rect_width} - 9'd1);
        r_rend <= 9'({1'b0, n_cmd.pos_y} + {1'b0, n_cmd.rect_height} - 9'd1);
    end

    assign o_ready = (r_state == mpfb_pkg::S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_read_data = r_rdata;
    assign o_clipped = r_clip;

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;
        n_clr = r_clr;
        n_c = r_c;
        n_r = r_r;
        n_clip = r_clip;
        n_rdata = r_rdata;
        n_mag = r_mag;
        n_mstep = r_mstep;
        n_rem = r_rem;
        n_ovalid = r_ovalid && !i_ready;
        we = 1'b0;
        addr = pix_addr;
        wdata = rdata;
        unique case (r_state) inside
            mpfb_pkg::S_CLR_INIT, mpfb_pkg::S_CLR: begin
                we = 1'b1;
                addr = r_clr[AW-1:0];
                wdata = 8'd0;
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(mpfb_pkg::DEPTH - 1)) begin
                    n_clr = '0;
                    n_state = (r_state == mpfb_pkg::S_CLR) ? mpfb_pkg::S_DONE
                                                           : mpfb_pkg::S_IDLE;
                end
            end
            mpfb_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_cmd = i_cmd;
                    n_c = {1'b0, i_cmd.pos_x};
                    n_r = {1'b0, i_cmd.pos_y};
                    n_clip = 1'b0;
                    n_rdata = 8'd0;
                    unique case (i_cmd.func) inside
                        mpfb_pkg::F_WRITE, mpfb_pkg::F_TOGGLE:
                            n_state = mpfb_pkg::S_PIX_RD;
                        mpfb_pkg::F_CLEAR: n_state = mpfb_pkg::S_CLR;
                        mpfb_pkg::F_READ: n_state = mpfb_pkg::S_RD;
                        default: n_state = i_cmd.empty ? mpfb_pkg::S_DONE
                                                       : mpfb_pkg::S_RECT_RD;
                    endcase
                end
            end
            mpfb_pkg::S_PIX_RD: begin
                if (in_buf) n_state = mpfb_pkg::S_PIX_WR;
                else begin
                    n_clip = 1'b1;
                    n_state = mpfb_pkg::S_DONE;
                end
            end
            mpfb_pkg::S_PIX_WR: begin
                we = 1'b1;
                if (r_cmd.func == mpfb_pkg::F_TOGGLE) wdata = rdata ^ bitm;
                else if (r_cmd.pixel_value) wdata = rdata | bitm;
                else wdata = rdata & ~bitm;
                n_state = mpfb_pkg::S_DONE;
            end
            mpfb_pkg::S_RD: begin
                addr = AW'(r_cmd.pos_y * mpfb_pkg::COLUMNS + {8'd0, r_cmd.pos_x});
                if ({1'b0, r_cmd.pos_x} < 9'(mpfb_pkg::COLUMNS)
                    && {1'b0, r_cmd.pos_y} < 9'(mpfb_pkg::PAGES)) begin
                    n_state = mpfb_pkg::S_RD_WAIT;
                end else begin
                    n_clip = 1'b1;
                    n_state = mpfb_pkg::S_DONE;
                end
            end
            mpfb_pkg::S_RD_WAIT: begin
                n_rdata = rdata;
                n_state = mpfb_pkg::S_DONE;
            end
            mpfb_pkg::S_RECT_RD: begin
                // decide whether this pixel is touched at all
                if (r_cmd.func == mpfb_pkg::F_PATO && border) begin
                    n_state = mpfb_pkg::S_RECT_WR;
                end else if (!in_buf) begin
                    n_clip = 1'b1;
                    n_state = mpfb_pkg::S_RECT_WR;
                end else if ((r_cmd.func == mpfb_pkg::F_PATB
                              || r_cmd.func == mpfb_pkg::F_PATO) && !border) begin
                    n_mag = term_w;
                    n_mstep = 5'd0;
                    n_rem = '0;
                    n_state = mpfb_pkg::S_MOD;
                end else begin
                    n_state = mpfb_pkg::S_RECT_WR;
                end
            end
            mpfb_pkg::S_MOD: begin
                // restoring remainder, one bit per cycle
                n_mag = {r_mag[23:0], 1'b0};
                if (r_cmd.pattern_period != 8'd0 && !trial[32]) n_rem = trial;
                else n_rem = {r_rem[31:0], r_mag[24]};
                n_mstep = r_mstep + 5'd1;
                if (r_mstep == 5'd24) n_state = mpfb_pkg::S_RECT_WR;
            end
            mpfb_pkg::S_RECT_WR: begin
                if (!(r_cmd.func == mpfb_pkg::F_PATO && border) && in_buf) begin
                    we = 1'b1;
                    if (r_cmd.func == mpfb_pkg::F_FILLED || border) wdata = rdata | bitm;
                    else if (r_cmd.func == mpfb_pkg::F_HOLLOW) wdata = rdata & ~bitm;
                    else if (r_rem == 33'd0) wdata = rdata | bitm;
                    else wdata = rdata & ~bitm;
                end
                n_state = mpfb_pkg::S_RECT_RD;
                if (r_c == r_cend) begin
                    n_c = {1'b0, r_cmd.pos_x};
                    n_r = r_r + 9'd1;
                    if (r_r == r_rend) n_state = mpfb_pkg::S_DONE;
                end else begin
                    n_c = r_c + 9'd1;
                end
            end
            mpfb_pkg::S_DONE: begin
                n_ovalid = 1'b1;
                n_state = mpfb_pkg::S_IDLE;
            end
            default: n_state = mpfb_pkg::S_IDLE;
        endcase
    end

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != mpfb_pkg::S_IDLE, !o_ready)
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == mpfb_pkg::S_DONE, r_ovalid)
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_read_data) && $stable(o_clipped))
endmodule

/* hdl/mono_page_framebuffer_rect_fill.sv */
// top level of the page frame buffer with rectangle drawing
// channel  | valid/ready          | payload
// input    | i_valid / o_ready    | i_func i_pos_x i_pos_y i_rect_width i_rect_height
//          |                      | i_pixel_value i_pattern_period i_pattern_slope
// output   | o_valid / i_ready    | o_read_data o_clipped
// pixel commands read then rewrite one byte, a read fetches one byte, clear zeroes every byte
// rectangles take a read and a write state per pixel, pattern interior pixels also pass
// through the bit-serial remainder unit, as set by the single memory port
// after reset a clearing pass over all COLUMNS*PAGES bytes runs before any item
// a two entry queue holds items while the back end works on one
`timescale 1ns / 1ps
module mono_page_framebuffer_rect_fill (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [7:0]  i_rect_width,
    input  logic [7:0]  i_rect_height,
    input  logic        i_pixel_value,
    input  logic [7:0]  i_pattern_period,
    input  logic signed [15:0] i_pattern_slope,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_data,
    output logic        o_clipped
);
    mpfb_pkg::t_cmd f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    // classify incoming items
    mpfb_front u_front (
        .i_valid(i_valid), .o_ready(o_ready), .i_func(i_func),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_rect_width(i_rect_width),
        .i_rect_height(i_rect_height), .i_pixel_value(i_pixel_value),
        .i_pattern_period(i_pattern_period), .i_pattern_slope(i_pattern_slope),
        .o_valid(f_valid), .i_ready(f_ready), .o_cmd(f_cmd)
    );
    // decoupling queue
    mpfb_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .o_ready(f_ready),
        .i_cmd(f_cmd), .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );
    // memory walker
    mpfb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .o_valid(o_valid), .i_ready(i_ready),
        .o_read_data(o_read_data), .o_clipped(o_clipped)
    );
endmodule
